// ===== design/rtc_coherent_snapshot_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// RTC snapshot decoder assertion macros
// Shared concurrent assertion forms for the snapshot decoder modules.
// ----------------------------------------------------------------------------
`ifndef RTC_COHERENT_SNAPSHOT_DECODER_MACROS_SVH
`define RTC_COHERENT_SNAPSHOT_DECODER_MACROS_SVH

// Implication checked at every rising clock edge, off while reset is asserted.
`define RTCCSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same form with the clock and reset names fixed to the house names.
`define RTCCSD_CHECK(lbl, prop, msg) \
    `RTCCSD_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

// ===== design/rtccsd_pkg.sv =====
// ----------------------------------------------------------------------------
// RTC snapshot decoder package
// Shared types and constants for the coherent snapshot decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtccsd_pkg;

    // Raw chip snapshot; seconds sit in the lowest byte.
    typedef struct packed {
        logic [7:0] century;
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } snap_t;

    // Bits compared between the two snapshots of a pair: the six low bytes (century excluded).
    localparam int CMP_W  = 48;

    // Finished pair handed from the pairing stage to the decoder.
    typedef struct packed {
        logic  fail;
        snap_t snap;
    } pair_evt_t;

    // Decoded time, lowest field first when packed into tdata.
    typedef struct packed {
        logic [11:0] calendar_year;
        logic [7:0]  time_month;
        logic [7:0]  time_day;
        logic [7:0]  time_hour;
        logic [7:0]  time_minute;
        logic [7:0]  time_second;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Decoder mode bits.
    typedef struct packed {
        logic binary_mode;
        logic hour_24_mode;
    } mode_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BINARY_MODE  = 2'd0;
    localparam logic [1:0] CFG_HOUR_24_MODE = 2'd1;
    localparam logic [1:0] CFG_MAX_PAIRS    = 2'd2;

    localparam logic [3:0] MAX_PAIRS_RESET  = 4'd8;

endpackage

// ===== design/rtccsd_pair.sv =====
// ----------------------------------------------------------------------------
// RTC snapshot pairing stage
// Groups snapshots in pairs, compares them and registers the pair outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rtc_coherent_snapshot_decoder_macros.svh"

module rtccsd_pair (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  restart,
    input  rtccsd_pkg::snap_t     snap,
    input  logic [3:0]            max_pairs,
    input  logic                  advance,
    output logic                  evt_valid,
    output rtccsd_pkg::pair_evt_t evt
);

    rtccsd_pkg::snap_t     first_reg, first_next;
    logic                  have_first_reg, have_first_next;
    logic [3:0]            pairs_tried_reg, pairs_tried_next;
    logic                  evt_valid_reg, evt_valid_next;
    rtccsd_pkg::pair_evt_t evt_reg, evt_next;

    logic       have_eff;
    logic [3:0] pairs_eff;
    logic [3:0] tried;
    logic       match;
    logic       emit;

    // A restart acts before the snapshot of the same transaction is used.
    assign have_eff  = have_first_reg & ~restart;
    assign pairs_eff = restart ? 4'd0 : pairs_tried_reg;
    assign tried     = pairs_eff + 4'd1;
    assign match     = (first_reg[rtccsd_pkg::CMP_W-1:0] == snap[rtccsd_pkg::CMP_W-1:0]);

    always_comb
    begin
        first_next       = first_reg;
        have_first_next  = have_first_reg;
        pairs_tried_next = pairs_tried_reg;
        evt_next         = evt_reg;
        emit             = 1'b0;
        if (in_fire)
        begin
            if (!have_eff)
            begin
                first_next       = snap;
                have_first_next  = 1'b1;
                pairs_tried_next = pairs_eff;
            end
            else
            begin
                have_first_next = 1'b0;
                if (match)
                begin
                    emit             = 1'b1;
                    evt_next.fail    = 1'b0;
                    evt_next.snap    = first_reg;
                    pairs_tried_next = 4'd0;
                end
                else if (tried >= max_pairs)
                begin
                    emit             = 1'b1;
                    evt_next.fail    = 1'b1;
                    evt_next.snap    = first_reg;
                    pairs_tried_next = 4'd0;
                end
                else
                begin
                    pairs_tried_next = tried;
                end
            end
        end
        evt_valid_next = (evt_valid_reg & ~advance) | emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg       <= '0;
            have_first_reg  <= 1'b0;
            pairs_tried_reg <= 4'd0;
            evt_valid_reg   <= 1'b0;
        end
        else
        begin
            first_reg       <= first_next;
            have_first_reg  <= have_first_next;
            pairs_tried_reg <= pairs_tried_next;
            evt_valid_reg   <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_reg <= evt_next;
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

    `RTCCSD_CHECK(a_first_stored, in_fire && !restart && !have_first_reg |=> have_first_reg,
        "first snapshot of a pair was not kept")
    `RTCCSD_CHECK(a_evt_held, evt_valid_reg && !advance |=> evt_valid_reg,
        "pending pair outcome dropped while the output was stalled")

endmodule

// ===== design/rtccsd_decode.sv =====
// ----------------------------------------------------------------------------
// RTC snapshot field decoder
// Turns a raw snapshot into binary 24-hour time and a four-digit year.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtccsd_decode (
    input  rtccsd_pkg::mode_t     mode,
    input  rtccsd_pkg::pair_evt_t evt,
    output rtccsd_pkg::result_t   result
);

    localparam logic [7:0]  HourNoon   = 8'd12;
    localparam logic [7:0]  CenturyLo  = 8'd19;
    localparam logic [7:0]  CenturyHi  = 8'd21;
    localparam logic [7:0]  YearPivot  = 8'd70;
    localparam logic [11:0] Base1900   = 12'd1900;
    localparam logic [11:0] Base2000   = 12'd2000;
    localparam logic [11:0] CenturyMul = 12'd100;

    // High nibble times ten plus low nibble; nibbles above nine are not checked.
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'b0000, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0000, v[3:0]};
    endfunction

    function automatic logic [7:0] field(input logic bin, input logic [7:0] v);
        return bin ? v : bcd_value(v);
    endfunction

    logic        pm;
    logic [7:0]  hr_raw;
    logic [7:0]  hr_dec;
    logic [7:0]  hr_12;
    logic [7:0]  yr_dec;
    logic [7:0]  cen_dec;
    logic        cen_ok;
    logic [11:0] year;

    assign pm     = ~mode.hour_24_mode & evt.snap.hour[7];
    assign hr_raw = pm ? {1'b0, evt.snap.hour[6:0]} : evt.snap.hour;
    assign hr_dec = field(mode.binary_mode, hr_raw);
    assign hr_12  = ((hr_dec == HourNoon) ? 8'd0 : hr_dec) + (pm ? HourNoon : 8'd0);

    assign yr_dec  = field(mode.binary_mode, evt.snap.year);
    assign cen_dec = field(mode.binary_mode, evt.snap.century);
    assign cen_ok  = (cen_dec >= CenturyLo) && (cen_dec <= CenturyHi);

    always_comb
    begin
        if (cen_ok)
            year = ({7'd0, cen_dec[4:0]} * CenturyMul) + {4'd0, yr_dec};
        else
            year = ((yr_dec >= YearPivot) ? Base1900 : Base2000) + {4'd0, yr_dec};
    end

    always_comb
    begin
        if (evt.fail)
        begin
            result = '0;
        end
        else
        begin
            result.time_second   = field(mode.binary_mode, evt.snap.second);
            result.time_minute   = field(mode.binary_mode, evt.snap.minute);
            result.time_hour     = mode.hour_24_mode ? hr_dec : hr_12;
            result.time_day      = field(mode.binary_mode, evt.snap.day);
            result.time_month    = field(mode.binary_mode, evt.snap.month);
            result.calendar_year = year;
        end
    end

endmodule

// ===== design/rtc_coherent_snapshot_decoder.sv =====
// ----------------------------------------------------------------------------
// RTC coherent snapshot decoder
// Pairs raw clock-chip snapshots, decodes agreeing pairs or reports a give-up.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata raw bytes, tuser restart
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata decoded time, tuser status
// cfg       in         cfg_we (no wait)               cfg_index, cfg_data
//
// One snapshot is accepted per cycle while s_axis_tready is high. A pair outcome
// is registered in the pairing stage at the second snapshot and moves to the
// output register whenever that register is empty or its result is being taken.
// Reset clears the pairing state, the attempt count and both valid flags, and
// returns the configuration to its reset values. A stalled output holds one
// result and the pairing stage one more; s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rtc_coherent_snapshot_decoder_macros.svh"

module rtc_coherent_snapshot_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // second[7:0], minute[15:8], hour[23:16], day[31:24], month[39:32],
    // year[47:40], century[55:48]
    input  logic [55:0] s_axis_tdata,
    // restart[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // time_second[7:0], time_minute[15:8], time_hour[23:16], time_day[31:24],
    // time_month[39:32], calendar_year[51:40], zero[55:52]
    output logic [55:0] m_axis_tdata,
    // status[0]
    output logic        m_axis_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    rtccsd_pkg::mode_t     mode_reg;
    logic [3:0]            max_pairs_reg;

    logic                  in_fire;
    logic                  advance;
    logic                  evt_valid;
    rtccsd_pkg::pair_evt_t evt;
    rtccsd_pkg::result_t   result;

    logic                  out_valid_reg, out_valid_next;
    rtccsd_pkg::result_t   out_data_reg;
    logic                  out_status_reg;

    assign advance       = ~out_valid_reg | m_axis_tready;
    assign s_axis_tready = ~evt_valid | advance;
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            max_pairs_reg <= rtccsd_pkg::MAX_PAIRS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rtccsd_pkg::CFG_BINARY_MODE:  mode_reg.binary_mode  <= cfg_data[0];
                rtccsd_pkg::CFG_HOUR_24_MODE: mode_reg.hour_24_mode <= cfg_data[0];
                rtccsd_pkg::CFG_MAX_PAIRS:    max_pairs_reg         <= cfg_data;
                default:                      ;
            endcase
        end
    end

    rtccsd_pair u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .restart   (s_axis_tuser),
        .snap      (rtccsd_pkg::snap_t'(s_axis_tdata)),
        .max_pairs (max_pairs_reg),
        .advance   (advance),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    rtccsd_decode u_decode (
        .mode   (mode_reg),
        .evt    (evt),
        .result (result)
    );

    assign out_valid_next = advance ? evt_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && evt_valid)
        begin
            out_data_reg   <= result;
            out_status_reg <= evt.fail;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(56 - rtccsd_pkg::RESULT_W){1'b0}}, out_data_reg};
    assign m_axis_tuser  = out_status_reg;

    `RTCCSD_CHECK(a_fail_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 56'd0,
        "failure transaction carries a nonzero time")
    `RTCCSD_CHECK(a_ready_only_full,
        !s_axis_tready |-> evt_valid && m_axis_tvalid && !m_axis_tready,
        "input stalled while a stage was free")

endmodule

// ===== tb/rtc_coherent_snapshot_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// RTC coherent snapshot decoder testbench
// Streams raw clock-chip snapshots into the decoder and compares every decoded
// time or give-up result against a cycle-free model of the pairing and BCD,
// 12/24-hour and century decoding. It covers directed corner cases, random
// reads in every mode, a long output stall and back-to-back traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtc_coherent_snapshot_decoder_tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 6;

    typedef struct {
        logic                status;
        rtccsd_pkg::result_t t;
    } decoded_time_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // second, minute, hour, day, month, year, century (lowest first)
    logic [55:0] s_axis_tdata;
    // restart
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // time_second, time_minute, time_hour, time_day, time_month, calendar_year
    logic [55:0] m_axis_tdata;
    // status
    logic        m_axis_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;

    // Mirror of the configuration and the pairing state.
    logic        mode_binary;
    logic        mode_h24;
    logic [3:0]  pair_limit;
    logic [55:0] held_snap;
    logic        held_valid;
    logic [3:0]  failed_pairs;

    decoded_time_t time_expect_q[$];

    int items_sent;
    int mismatches;
    int idle_cycles;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;
    int stall_left;
    int run_left;

    rtc_coherent_snapshot_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Time decoding and pairing model
    // ------------------------------------------------------------------------
    function automatic logic [7:0] bcd_byte_value(logic [7:0] v);
        return 8'(v[7:4] * 10 + v[3:0]);
    endfunction

    function automatic rtccsd_pkg::result_t decode_time(rtccsd_pkg::snap_t s);
        rtccsd_pkg::result_t t;
        logic [7:0]          hr_v;
        logic [7:0]          cen_v;
        logic [7:0]          yr_v;
        logic                pm;
        int unsigned         full;
        hr_v = s.hour;
        pm   = 1'b0;
        t.time_second = s.second;
        t.time_minute = s.minute;
        t.time_day    = s.day;
        t.time_month  = s.month;
        yr_v  = s.year;
        cen_v = s.century;
        if (!mode_h24 && hr_v[7])
        begin
            hr_v[7] = 1'b0;
            pm      = 1'b1;
        end
        if (!mode_binary)
        begin
            t.time_second = bcd_byte_value(t.time_second);
            t.time_minute = bcd_byte_value(t.time_minute);
            t.time_day    = bcd_byte_value(t.time_day);
            t.time_month  = bcd_byte_value(t.time_month);
            hr_v  = bcd_byte_value(hr_v);
            yr_v  = bcd_byte_value(yr_v);
            cen_v = bcd_byte_value(cen_v);
        end
        // In 12-hour form, 12 o'clock counts as hour zero before PM is added.
        if (!mode_h24)
        begin
            if (hr_v == 8'd12)
                hr_v = 8'd0;
            if (pm)
                hr_v = hr_v + 8'd12;
        end
        t.time_hour = hr_v;
        if (cen_v >= 19 && cen_v <= 21)
            full = cen_v * 100 + yr_v;
        else if (yr_v >= 70)
            full = 1900 + yr_v;
        else
            full = 2000 + yr_v;
        t.calendar_year = full[11:0];
        return t;
    endfunction

    function automatic void predict_snapshot(logic rs, logic [55:0] snap);
        decoded_time_t d;
        if (rs)
        begin
            held_valid   = 1'b0;
            failed_pairs = 4'd0;
        end
        if (!held_valid)
        begin
            held_snap  = snap;
            held_valid = 1'b1;
        end
        else
        begin
            held_valid = 1'b0;
            // The century byte takes no part in the agreement check.
            if (held_snap[rtccsd_pkg::CMP_W-1:0] == snap[rtccsd_pkg::CMP_W-1:0])
            begin
                d.status     = 1'b0;
                d.t          = decode_time(held_snap);
                failed_pairs = 4'd0;
                time_expect_q.push_back(d);
            end
            else
            begin
                failed_pairs = failed_pairs + 4'd1;
                if (failed_pairs >= pair_limit)
                begin
                    d.status     = 1'b1;
                    d.t          = '0;
                    failed_pairs = 4'd0;
                    time_expect_q.push_back(d);
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] rand_field();
        if ($urandom_range(0, 2) == 0)
            return 8'($urandom_range(0, 255));
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    function automatic logic [55:0] rand_snapshot();
        logic [55:0] s;
        int          i;
        for (i = 0; i < 6; i++)
            s[i*8 +: 8] = rand_field();
        // Bias the century toward the 19..21 window in both encodings.
        case ($urandom_range(0, 7))
            0: s[55:48] = 8'h19;
            1: s[55:48] = 8'h20;
            2: s[55:48] = 8'h21;
            3: s[55:48] = 8'd19;
            4: s[55:48] = 8'd20;
            5: s[55:48] = 8'd21;
            default: s[55:48] = rand_field();
        endcase
        return s;
    endfunction

    function automatic logic [55:0] disturb(logic [55:0] s);
        int k;
        k = $urandom_range(0, 5);
        s[k*8 +: 8] = s[k*8 +: 8] ^ 8'($urandom_range(1, 255));
        return s;
    endfunction

    task automatic send_snapshot(input logic rs, input logic [55:0] snap);
        int gap;
        gap = tx_idle_on ? gap_cycles() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= snap;
        s_axis_tuser  <= rs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_snapshot(rs, snap);
        items_sent++;
    endtask

    task automatic send_pair(input logic rs, input logic [55:0] a, input logic [55:0] b);
        send_snapshot(rs, a);
        send_snapshot(1'b0, b);
    endtask

    // Lets the block run dry so that the configuration may change.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (time_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic bin, input logic h24, input logic [3:0] maxp);
        cfg_we    <= 1'b1;
        cfg_index <= rtccsd_pkg::CFG_BINARY_MODE;
        cfg_data  <= {3'($urandom_range(0, 7)), bin};
        @(posedge clk);
        cfg_index <= rtccsd_pkg::CFG_HOUR_24_MODE;
        cfg_data  <= {3'($urandom_range(0, 7)), h24};
        @(posedge clk);
        cfg_index <= rtccsd_pkg::CFG_MAX_PAIRS;
        cfg_data  <= maxp;
        @(posedge clk);
        cfg_we      <= 1'b0;
        mode_binary = bin;
        mode_h24    = h24;
        pair_limit  = maxp;
    endtask

    // One read: some disagreeing pairs, then an agreeing pair whose second
    // snapshot may carry a different century.
    task automatic run_read(input int bad_pairs, input logic rs);
        logic [55:0] a;
        int          k;
        for (k = 0; k < bad_pairs; k++)
        begin
            a = rand_snapshot();
            send_pair(rs && k == 0, a, disturb(a));
        end
        a = rand_snapshot();
        if ($urandom_range(0, 3) == 0)
            send_pair(rs && bad_pairs == 0, a, {8'($urandom_range(0, 255)), a[47:0]});
        else
            send_pair(rs && bad_pairs == 0, a, a);
    endtask

    task automatic run_random_reads(input int n_items);
        int stop_at;
        int bad;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 3) == 0)
                    bad = $urandom_range(0, pair_limit + 1);
                else
                    bad = $urandom_range(0, 2);
                run_read(bad, $urandom_range(0, 1));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_snapshot($urandom_range(0, 3) == 0, rand_snapshot());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Snapshots are written as {century, year, month, day, hour, minute, second}.
    task automatic test_directed_decode();
        logic [55:0] a;
        // Reset configuration: BCD, 12-hour, eight pairs.
        send_pair(1'b1, 56'h0, 56'h0);
        send_pair(1'b0, {7{8'hFF}}, {7{8'hFF}});
        // Midnight in 12-hour form and noon with the PM bit.
        send_pair(1'b0, {8'h20, 8'h24, 8'h12, 8'h31, 8'h12, 8'h59, 8'h59},
                  {8'h20, 8'h24, 8'h12, 8'h31, 8'h12, 8'h59, 8'h59});
        send_pair(1'b0, {8'h19, 8'h99, 8'h01, 8'h01, 8'h92, 8'h00, 8'h00},
                  {8'h00, 8'h99, 8'h01, 8'h01, 8'h92, 8'h00, 8'h00});
        send_pair(1'b0, {8'h21, 8'h00, 8'h06, 8'h15, 8'h81, 8'h30, 8'h45},
                  {8'h21, 8'h00, 8'h06, 8'h15, 8'h81, 8'h30, 8'h45});
        // Centuries just outside the window fall back to the 70/69 split.
        send_pair(1'b0, {8'h18, 8'h70, 8'h12, 8'h31, 8'h11, 8'h5A, 8'hFA},
                  {8'h18, 8'h70, 8'h12, 8'h31, 8'h11, 8'h5A, 8'hFA});
        send_pair(1'b0, {8'h22, 8'h69, 8'h02, 8'h28, 8'h23, 8'h01, 8'h02},
                  {8'h22, 8'h69, 8'h02, 8'h28, 8'h23, 8'h01, 8'h02});
        // A restart on what would be the second snapshot starts a new pair.
        a = {8'h20, 8'h25, 8'h07, 8'h04, 8'h08, 8'h15, 8'h30};
        send_snapshot(1'b0, {8'h20, 8'h25, 8'h07, 8'h04, 8'h09, 8'h15, 8'h30});
        send_pair(1'b1, a, a);
        // Give up at the first disagreeing pair, with a limit of one and zero.
        settle();
        set_config(1'b0, 1'b0, 4'd1);
        send_pair(1'b0, a, disturb(a));
        settle();
        set_config(1'b0, 1'b0, 4'd0);
        send_pair(1'b0, a, disturb(a));
        // Binary, 24-hour: the top hour bit is kept and the century is binary.
        settle();
        set_config(1'b1, 1'b1, 4'd15);
        send_pair(1'b0, {8'd20, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
                  {8'd20, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        settle();
    endtask

    task automatic test_random_modes();
        logic [3:0] limits [7] = '{4'd15, 4'd1, 4'd8, 4'd2, 4'd0, 4'd15, 4'd3};
        int         p;
        limits[6] = 4'($urandom_range(1, 15));
        for (p = 0; p < 7; p++)
        begin
            set_config(p[0], p[1], limits[p]);
            run_random_reads(210);
            settle();
        end
    endtask

    // The output holds off for a long stretch while agreeing pairs keep
    // coming, so both internal stages fill and the input stalls.
    task automatic test_output_stall();
        logic [55:0] a;
        set_config(1'b0, 1'b0, 4'd8);
        hold_req   = 1'b1;
        tx_idle_on = 1'b0;
        repeat (16)
        begin
            a = rand_snapshot();
            send_pair(1'b0, a, a);
        end
        tx_idle_on = 1'b1;
        settle();
    endtask

    task automatic test_back_to_back();
        set_config(1'b1, 1'b0, 4'd2);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random_reads(150);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        settle();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = rtccsd_pkg::CFG_BINARY_MODE;
        cfg_data      = 4'd0;
        mode_binary   = 1'b0;
        mode_h24      = 1'b0;
        pair_limit    = rtccsd_pkg::MAX_PAIRS_RESET;
        held_snap     = '0;
        held_valid    = 1'b0;
        failed_pairs  = 4'd0;
        items_sent    = 0;
        mismatches    = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_req      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_decode();
        test_random_modes();
        test_output_stall();
        test_back_to_back();

        settle();
        if (mismatches == 0 && time_expect_q.size() == 0)
            $display("rtc_coherent_snapshot_decoder verification clean");
        else
            $display("rtc_coherent_snapshot_decoder verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: ready pattern, result checks and watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
                run_left   = 0;
            end
            if (stall_left == 0 && run_left == 0 && rx_idle_on)
            begin
                if ($urandom_range(0, 99) < 40)
                begin
                    if ($urandom_range(0, 99) < 90)
                        stall_left = $urandom_range(1, 3);
                    else
                        stall_left = $urandom_range(15, 40);
                end
                else
                    run_left = $urandom_range(1, 12);
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (run_left > 0)
                    run_left--;
            end
        end
    end

    task automatic report_field(input string field, input int unsigned want_v,
                                input int unsigned got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field,
                     want_v, got_v);
    endtask

    always @(posedge clk)
    begin
        decoded_time_t       want;
        rtccsd_pkg::result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[rtccsd_pkg::RESULT_W-1:0];
            if (time_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with nothing expected: status %0d data %h",
                             $realtime, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = time_expect_q.pop_front();
                if (m_axis_tuser !== want.status)
                    report_field("status", want.status, m_axis_tuser);
                if (got.time_second !== want.t.time_second)
                    report_field("time_second", want.t.time_second, got.time_second);
                if (got.time_minute !== want.t.time_minute)
                    report_field("time_minute", want.t.time_minute, got.time_minute);
                if (got.time_hour !== want.t.time_hour)
                    report_field("time_hour", want.t.time_hour, got.time_hour);
                if (got.time_day !== want.t.time_day)
                    report_field("time_day", want.t.time_day, got.time_day);
                if (got.time_month !== want.t.time_month)
                    report_field("time_month", want.t.time_month, got.time_month);
                if (got.calendar_year !== want.t.calendar_year)
                    report_field("calendar_year", want.t.calendar_year,
                                 got.calendar_year);
                if (m_axis_tdata[55:rtccsd_pkg::RESULT_W] !== '0)
                    report_field("tdata padding", 0,
                                 m_axis_tdata[55:rtccsd_pkg::RESULT_W]);
            end
        end
    end

    // Ends the run when no transaction happens on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("rtc_coherent_snapshot_decoder verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
